// ===== src/ttceb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttceb_pkg: shared types and constants of the ttc emergency brake unit
// widths, register map, command codes and the quarter-wave cosine tables
// ----------------------------------------------------------------------------
package ttceb_pkg;

  localparam int MAX_BEAMS   = 2048;
  localparam int COS_ENTRIES = 1024;

  localparam int IDX_W   = $clog2(COS_ENTRIES);
  localparam int QTR_W   = IDX_W - 2;
  localparam int COS_QTR = COS_ENTRIES / 4;
  localparam int CNT_W   = $clog2(MAX_BEAMS + 1);

  localparam int CFG_W   = 16;
  localparam int SPEED_W = 16;
  localparam int RANGE_W = 16;
  localparam int POS_W   = 12;
  localparam int COS_W   = 16;
  localparam int SP_W    = CFG_W + SPEED_W + 1;
  localparam int P_W     = SP_W + COS_W;
  localparam int LIM_W   = P_W - 15;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ANGLE_START  = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD_MS = 2'd2;

  localparam logic [CFG_W-1:0] RST_ANGLE_START  = 16'd32768;
  localparam logic [CFG_W-1:0] RST_ANGLE_STEP   = 16'd46;
  localparam logic [CFG_W-1:0] RST_THRESHOLD_MS = 16'd500;

  // item commands
  localparam logic CMD_SPEED = 1'b0;
  localparam logic CMD_BEAM  = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam int RANGE_SCALE = 1000;

  // taylor term divisors (n+1)(n+2)
  localparam longint unsigned COS_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};
  localparam longint unsigned SIN_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  typedef logic [COS_W-1:0] cos_tab_t [COS_QTR];

  // q30 taylor series over a reduced angle, rounded to a q15 magnitude
  function automatic logic [COS_W-1:0] trig_mag(input longint unsigned x, input bit want_sin);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint unsigned mag;
    x2   = (x * x) >> 30;
    term = want_sin ? x : Q30_ONE;
    acc  = $signed(term);
    for (int i = 0; i < 10; i++) begin
      term = (term * x2) >> 30;
      term = want_sin ? term / SIN_DIV[i] : term / COS_DIV[i];
      if ((i % 2) == 0) acc = acc - $signed(term);
      else              acc = acc + $signed(term);
    end
    mag = ($unsigned(acc) + 64'd16384) >> 15;
    return mag[COS_W-1:0];
  endfunction

  function automatic cos_tab_t build_tab(input bit want_sin);
    cos_tab_t        tab;
    longint unsigned x;
    for (int r = 0; r < COS_QTR; r++) begin
      x      = (longint'(r) * 4 * HALF_PI_Q30) / COS_ENTRIES;
      tab[r] = trig_mag(x, want_sin);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_tab(1'b0);
  localparam cos_tab_t SIN_TAB = build_tab(1'b1);

  // q1.15 cosine of a 16-bit phase
  function automatic logic signed [COS_W-1:0] cos_q15(input logic [15:0] phase);
    logic [IDX_W-1:0] idx;
    logic [1:0]       quad;
    logic [QTR_W-1:0] rem;
    logic [COS_W-1:0] mag;
    logic [COS_W:0]   negv;
    idx  = phase[15 -: IDX_W];
    quad = idx[IDX_W-1 -: 2];
    rem  = idx[QTR_W-1:0];
    mag  = quad[0] ? SIN_TAB[rem] : COS_TAB[rem];
    negv = '0 - {1'b0, mag};
    if (quad[1] ^ quad[0]) return negv[COS_W-1:0];
    else if (mag > 16'h7FFF) return 16'h7FFF;
    else return mag;
  endfunction

endpackage

// ===== src/ttceb_in_if.sv =====
// ----------------------------------------------------------------------------
// ttceb_in_if: input item channel
// valid/ready channel carrying speed updates and lidar beams
// ----------------------------------------------------------------------------
interface ttceb_in_if import ttceb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [SPEED_W-1:0] speed_mm_s;
  logic [RANGE_W-1:0]        range_mm;
  logic                      range_valid;
  logic                      last_beam;

  modport source (output valid, command, speed_mm_s, range_mm, range_valid, last_beam,
                  input ready);
  modport sink   (input valid, command, speed_mm_s, range_mm, range_valid, last_beam,
                  output ready);
endinterface

// ===== src/ttceb_out_if.sv =====
// ----------------------------------------------------------------------------
// ttceb_out_if: result item channel
// valid/ready channel carrying the per-scan brake decision
// ----------------------------------------------------------------------------
interface ttceb_out_if import ttceb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             brake;
  logic [POS_W-1:0] positive_beams;

  modport source (output valid, brake, positive_beams, input ready);
  modport sink   (input valid, brake, positive_beams, output ready);
endinterface

// ===== src/ttc_emergency_brake_unit.sv =====
// ----------------------------------------------------------------------------
// ttc_emergency_brake_unit: time to collision emergency brake
// per-beam ttc check against a threshold without division, one result per scan
// ----------------------------------------------------------------------------
//
//  channel   | kind          | moves
//  ----------+---------------+-------------------------------------------------
//  in_item   | valid/ready   | beam or speed update, one per cycle unless stalled
//  out_item  | valid/ready   | brake flag and positive beam count, on last beam
//  apb       | psel/penable  | angle_start, angle_step, threshold_ms
//
//  one item per cycle while out_item does not stall a last beam; out_item.valid
//  rises after the last beam passes cosine reg (accept), product reg, output reg
//  speed updates take effect at accept and never reach the output
//  reset (rst_n low, synchronous) empties the stages and loads register defaults
//  out_item stalls only back up when a last beam waits for a full output reg;
//  other beams keep flowing through the compare stage
//
module ttc_emergency_brake_unit import ttceb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ttceb_in_if.sink          in_item,
  ttceb_out_if.source       out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [CFG_W-1:0] angle_start_r;
  logic [CFG_W-1:0] angle_step_r;
  logic [CFG_W-1:0] threshold_ms_r;

  // scan state kept at accept
  logic signed [SP_W-1:0] speed_product_r;
  logic signed [SP_W-1:0] speed_product_nxt;
  logic [15:0]            beam_phase_r;
  logic [15:0]            phase_use;
  logic                   in_scan_r;

  // stage 1: beam with its cosine
  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic                     s1_ok_r;
  logic [RANGE_W-1:0]       s1_range_r;
  logic signed [COS_W-1:0]  s1_cos_r;

  // stage 2: beam with speed * cosine
  logic                   s2_valid_r;
  logic                   s2_last_r;
  logic                   s2_ok_r;
  logic [RANGE_W-1:0]     s2_range_r;
  logic signed [P_W-1:0]  s2_p_r;
  logic signed [P_W-1:0]  p_nxt;

  // scan accumulators
  logic [CNT_W-1:0] pos_count_r;
  logic [CNT_W-1:0] pos_count_nxt;
  logic             brake_pend_r;
  logic             brake_pend_nxt;

  // output register
  logic             out_valid_r;
  logic             out_brake_r;
  logic [POS_W-1:0] out_count_r;

  // handshake
  logic out_take;
  logic s2_go;
  logic s2_free;
  logic s1_go;
  logic s1_free;
  logic in_acc;
  logic beam_acc;
  logic speed_acc;
  logic cfg_wr;

  // compare
  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] range_scaled;
  logic             hit_pos;
  logic             hit_brake;

  // ---------------------------------------------------------------- handshake
  // a stage frees up when it is empty or its item moves on; only a last beam
  // needs room in the output register
  assign out_take = !out_valid_r || out_item.ready;
  assign s2_go    = s2_valid_r && (!s2_last_r || out_take);
  assign s2_free  = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_go;

  assign in_item.ready = s1_free;
  assign in_acc    = in_item.valid && s1_free;
  assign beam_acc  = in_acc && (in_item.command == CMD_BEAM);
  assign speed_acc = in_acc && (in_item.command == CMD_SPEED);

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_ANGLE_START:  prdata = DATA_W'(angle_start_r);
      REG_ANGLE_STEP:   prdata = DATA_W'(angle_step_r);
      REG_THRESHOLD_MS: prdata = DATA_W'(threshold_ms_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r  <= RST_ANGLE_START;
      angle_step_r   <= RST_ANGLE_STEP;
      threshold_ms_r <= RST_THRESHOLD_MS;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ANGLE_START:  angle_start_r  <= pwdata[CFG_W-1:0];
        REG_ANGLE_STEP:   angle_step_r   <= pwdata[CFG_W-1:0];
        REG_THRESHOLD_MS: threshold_ms_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  // threshold times speed, held until the next speed update
  assign speed_product_nxt = $signed({{(SP_W-CFG_W){1'b0}}, threshold_ms_r})
                           * $signed({{(SP_W-SPEED_W){in_item.speed_mm_s[SPEED_W-1]}},
                                      in_item.speed_mm_s});

  // first beam of a scan restarts the phase accumulator
  assign phase_use = in_scan_r ? beam_phase_r : angle_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_product_r <= '0;
      beam_phase_r    <= '0;
      in_scan_r       <= 1'b0;
    end else begin
      if (speed_acc) speed_product_r <= speed_product_nxt;
      if (beam_acc) begin
        if (in_item.last_beam) begin
          beam_phase_r <= '0;
          in_scan_r    <= 1'b0;
        end else begin
          beam_phase_r <= phase_use + angle_step_r;
          in_scan_r    <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (s1_free) s1_valid_r <= beam_acc;
  end

  always_ff @(posedge clk) begin
    if (beam_acc) begin
      s1_last_r  <= in_item.last_beam;
      s1_ok_r    <= in_item.range_valid && (in_item.range_mm != '0);
      s1_range_r <= in_item.range_mm;
      s1_cos_r   <= cos_q15(phase_use);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // speed_product_r is read as the beam leaves stage 1, so a later speed
  // update written at that same edge does not reach this beam
  assign p_nxt = P_W'(speed_product_r) * P_W'(s1_cos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else if (s2_free) s2_valid_r <= s1_go;
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_last_r  <= s1_last_r;
      s2_ok_r    <= s1_ok_r;
      s2_range_r <= s1_range_r;
      s2_p_r     <= p_nxt;
    end
  end

  // ---------------------------------------------------------------- compare
  // ttc <= threshold  <=>  range * 1000 <= (speed * threshold * cos) >> 15
  assign hit_pos      = s2_ok_r && (s2_p_r > 0);
  assign lim          = s2_p_r[P_W-1:15];
  assign range_scaled = LIM_W'(s2_range_r) * LIM_W'(RANGE_SCALE);
  assign hit_brake    = hit_pos && (range_scaled <= lim);

  always_comb begin
    pos_count_nxt = pos_count_r;
    if (hit_pos && (pos_count_r < CNT_W'(MAX_BEAMS))) pos_count_nxt = pos_count_r + 1'b1;
    brake_pend_nxt = brake_pend_r || hit_brake;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_count_r  <= '0;
      brake_pend_r <= 1'b0;
    end else if (s2_go) begin
      if (s2_last_r) begin
        pos_count_r  <= '0;
        brake_pend_r <= 1'b0;
      end else begin
        pos_count_r  <= pos_count_nxt;
        brake_pend_r <= brake_pend_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (s2_go && s2_last_r) out_valid_r <= 1'b1;
    else if (out_item.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last_r) begin
      out_brake_r <= brake_pend_nxt;
      out_count_r <= POS_W'(pos_count_nxt);
    end
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.brake          = out_brake_r;
  assign out_item.positive_beams = out_count_r;

  // ---------------------------------------------------------------- checks
  // a last beam ends the scan and parks the phase
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (beam_acc && in_item.last_beam) |=> (!in_scan_r && (beam_phase_r == '0)))
    else $error("scan state not cleared after last beam");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_count_r <= CNT_W'(MAX_BEAMS))
    else $error("positive count above saturation");

  // a pending brake always comes with at least one positive beam
  a_brake_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    brake_pend_r |-> (pos_count_r != '0))
    else $error("brake pending with no positive beam");

  // a result only appears when a last beam leaves the compare stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_last_r))
    else $error("result without a last beam");

endmodule
